FILE: hw/rtl/joint_jog_ramp_controller_assert.svh
// Assertion macros for the joint jog ramp controller.
// Expects clk and arst_n in the scope of each use.
`ifndef JOINT_JOG_RAMP_CONTROLLER_ASSERT_SVH
`define JOINT_JOG_RAMP_CONTROLLER_ASSERT_SVH
`ifndef SYNTHESIS
`define JJR_ASSERT_IMPLY(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("joint jog ramp controller: check failed");
`define JJR_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("joint jog ramp controller: check failed");
`else
`define JJR_ASSERT_IMPLY(name, ante, cons)
`define JJR_ASSERT_NEXT(name, ante, cons)
`endif
`endif

FILE: hw/rtl/jjr_pkg.sv
// Shared types and constants of the joint jog ramp controller.
// No dependencies; used by jjr_ctrl, jjr_dp and the top level.
`timescale 1ns / 1ps
`default_nettype none
package jjr_pkg;

	// operation codes carried in the input tuser
	localparam logic [1:0] OP_JOYSTICK = 2'd0;
	localparam logic [1:0] OP_TICK     = 2'd1;
	localparam logic [1:0] OP_STOP     = 2'd2;

	// result kinds carried in the output tuser
	localparam logic KIND_REPLY = 1'b0;
	localparam logic KIND_GOAL  = 1'b1;

	// configuration register indexes
	localparam logic [2:0] REG_MIN_POSITION   = 3'd0;
	localparam logic [2:0] REG_MAX_POSITION   = 3'd1;
	localparam logic [2:0] REG_JOG_SPEED      = 3'd2;
	localparam logic [2:0] REG_ACCEL_LIMIT    = 3'd3;
	localparam logic [2:0] REG_SUPPRESS_LOWER = 3'd4;
	localparam logic [2:0] REG_DEADMAN_INDEX  = 3'd5;
	localparam logic [2:0] REG_INCREASE_INDEX = 3'd6;
	localparam logic [2:0] REG_DECREASE_INDEX = 3'd7;

	// prediction horizon, 0.25 s in unsigned Q0.16
	localparam logic [15:0] LOOKAHEAD_TIME = 16'h4000;

	// commands from the controller to the datapath
	typedef struct packed {
		logic latch_in;   // capture the accepted item
		logic clear_jog;  // external stop
		logic joy_apply;  // apply joystick sample, load reply
		logic mul_en;     // capture shared product
		logic mul_sum;    // multiplicand: velocity sum (else accel limit)
		logic mul_dt;     // multiplier: elapsed time (else lookahead)
		logic ramp_en;    // capture ramped velocity
		logic goal_en;    // capture goal position and velocity
		logic update_en;  // advance state, load goal result
	} cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic [1:0] op;
		logic       active;
		logic       out_free;
	} status_t;

endpackage
`default_nettype wire

FILE: hw/rtl/jjr_ctrl.sv
// Sequencer of the joint jog ramp controller.
// Depends on jjr_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none
module jjr_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_ready,
	input  jjr_pkg::status_t status,
	output jjr_pkg::cmd_t    cmd
);
	import jjr_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_DISP = 4'd1;
	localparam logic [3:0] ST_JOY  = 4'd2;
	localparam logic [3:0] ST_RL   = 4'd3;
	localparam logic [3:0] ST_RV   = 4'd4;
	localparam logic [3:0] ST_AL   = 4'd5;
	localparam logic [3:0] ST_GP   = 4'd6;
	localparam logic [3:0] ST_RD   = 4'd7;
	localparam logic [3:0] ST_NV   = 4'd8;
	localparam logic [3:0] ST_AD   = 4'd9;
	localparam logic [3:0] ST_UPD  = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_nxt;

	assign in_ready = (state_q == ST_IDLE);

	// next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					state_nxt    = ST_DISP;
				end
			end
			ST_DISP: begin
				case (status.op)
					OP_JOYSTICK: state_nxt = ST_JOY;
					OP_TICK:     state_nxt = status.active ? ST_RL : ST_IDLE;
					OP_STOP: begin
						cmd.clear_jog = 1'b1;
						state_nxt     = ST_IDLE;
					end
					default:     state_nxt = ST_IDLE;
				endcase
			end
			ST_JOY: begin
				if (status.out_free) begin
					cmd.joy_apply = 1'b1;
					state_nxt     = ST_IDLE;
				end
			end
			// goal: ramp and travel over the lookahead
			ST_RL: begin
				cmd.mul_en = 1'b1;
				state_nxt  = ST_RV;
			end
			ST_RV: begin
				cmd.ramp_en = 1'b1;
				state_nxt   = ST_AL;
			end
			ST_AL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sum = 1'b1;
				state_nxt   = ST_GP;
			end
			ST_GP: begin
				cmd.goal_en = 1'b1;
				state_nxt   = ST_RD;
			end
			// state: ramp and travel over the elapsed time
			ST_RD: begin
				cmd.mul_en = 1'b1;
				cmd.mul_dt = 1'b1;
				state_nxt  = ST_NV;
			end
			ST_NV: begin
				cmd.mul_dt  = 1'b1;
				cmd.ramp_en = 1'b1;
				state_nxt   = ST_AD;
			end
			ST_AD: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sum = 1'b1;
				cmd.mul_dt  = 1'b1;
				state_nxt   = ST_UPD;
			end
			ST_UPD: begin
				if (status.out_free) begin
					cmd.update_en = 1'b1;
					state_nxt     = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/jjr_dp.sv
// Datapath of the joint jog ramp controller: configuration, jog state,
// shared multiplier, ramp and clamp logic, output register. Uses jjr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module jjr_dp #(
	parameter int BUTTON_COUNT = 16
) (
	input  wire                    clk,
	input  wire                    arst_n,
	// configuration writes
	input  wire                    cfg_valid,
	output logic                   cfg_ready,
	input  wire  [2:0]             cfg_index,
	input  wire  [31:0]            cfg_data,
	// accepted item fields
	input  wire  [1:0]             in_operation,
	input  wire  [BUTTON_COUNT-1:0] in_buttons,
	input  wire  [31:0]            in_measured_position,
	input  wire                    in_measured_valid,
	input  wire  [15:0]            in_elapsed_time,
	// result register
	output logic                   out_valid,
	input  wire                    out_ready,
	output logic                   out_result_kind,
	output logic                   out_suppress_request,
	output logic [31:0]            out_goal_position,
	output logic [31:0]            out_goal_velocity,
	// sequencer link
	input  jjr_pkg::cmd_t          cmd,
	output jjr_pkg::status_t       status
);
	import jjr_pkg::*;

	// configuration registers
	logic [31:0] min_pos_q, max_pos_q;
	logic [30:0] jog_speed_q, accel_q;
	logic        suppress_q;
	logic [3:0]  deadman_idx_q, increase_idx_q, decrease_idx_q;

	// jog state
	logic [31:0] joint_q, target_q, prev_q;
	logic        active_q;

	// captured item
	logic [1:0]              op_q;
	logic [BUTTON_COUNT-1:0] buttons_q;
	logic [31:0]             meas_q;
	logic                    meas_valid_q;
	logic [15:0]             dt_q;

	// working registers
	logic signed [49:0] prod_q;
	logic [31:0]        vel_q, gv_q, gp_q;

	// result register
	logic        out_valid_q;
	logic        kind_q, sup_q;
	logic [31:0] pos_out_q, vel_out_q;

	logic               btn_dead, btn_inc, btn_dec;
	logic signed [32:0] vel_sum;
	logic signed [32:0] mul_a;
	logic signed [16:0] mul_b;
	logic signed [49:0] prod;
	logic [30:0]        delta;
	logic signed [33:0] p34, d34, up34, dn34, ramp34;
	logic signed [33:0] joint34, travel34, pos34, clamp34;
	logic signed [33:0] min34, max34;
	logic               out_free;

	assign cfg_ready = 1'b1;

	// button lookup; an index past the vector reads as released
	function automatic logic button_at(input logic [BUTTON_COUNT-1:0] b,
	                                   input logic [3:0] idx);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < BUTTON_COUNT; i++) begin
			if (int'(idx) == i) hit = b[i];
		end
		return hit;
	endfunction

	assign btn_dead = button_at(buttons_q, deadman_idx_q);
	assign btn_inc  = button_at(buttons_q, increase_idx_q);
	assign btn_dec  = button_at(buttons_q, decrease_idx_q);

	// shared multiplier operands
	assign vel_sum = {vel_q[31], vel_q} + {prev_q[31], prev_q};
	assign mul_a   = cmd.mul_sum ? vel_sum : {2'b00, accel_q};
	assign mul_b   = cmd.mul_dt ? {1'b0, dt_q} : {1'b0, LOOKAHEAD_TIME};
	assign prod    = mul_a * mul_b;

	// ramp previous velocity toward target by at most delta
	assign delta  = prod_q[46:16];
	assign p34    = {{2{prev_q[31]}}, prev_q};
	assign d34    = {{2{target_q[31]}}, target_q};
	assign up34   = p34 + {3'b000, delta};
	assign dn34   = p34 - {3'b000, delta};
	always_comb begin
		if (d34 > p34) begin
			ramp34 = (up34 > d34) ? d34 : up34;
		end else begin
			ramp34 = (dn34 < d34) ? d34 : dn34;
		end
	end

	// trapezoid travel (floor shift by 17) and position clamp
	assign joint34  = {{2{joint_q[31]}}, joint_q};
	assign travel34 = {prod_q[49], prod_q[49:17]};
	assign pos34    = joint34 + travel34;
	assign min34    = {{2{min_pos_q[31]}}, min_pos_q};
	assign max34    = {{2{max_pos_q[31]}}, max_pos_q};
	always_comb begin
		clamp34 = pos34;
		if (clamp34 > max34) clamp34 = max34;
		if (clamp34 < min34) clamp34 = min34;
	end

	assign out_free = !out_valid_q || out_ready;

	assign status.op       = op_q;
	assign status.active   = active_q;
	assign status.out_free = out_free;

	// configuration and jog state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_pos_q      <= 32'sd0;
			max_pos_q      <= 32'd26214;
			jog_speed_q    <= 31'd4915;
			accel_q        <= 31'd16384;
			suppress_q     <= 1'b0;
			deadman_idx_q  <= 4'd10;
			increase_idx_q <= 4'd12;
			decrease_idx_q <= 4'd14;
			joint_q        <= '0;
			target_q       <= '0;
			prev_q         <= '0;
			active_q       <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_MIN_POSITION:   min_pos_q      <= cfg_data;
					REG_MAX_POSITION:   max_pos_q      <= cfg_data;
					REG_JOG_SPEED:      jog_speed_q    <= cfg_data[30:0];
					REG_ACCEL_LIMIT:    accel_q        <= cfg_data[30:0];
					REG_SUPPRESS_LOWER: suppress_q     <= cfg_data[0];
					REG_DEADMAN_INDEX:  deadman_idx_q  <= cfg_data[3:0];
					REG_INCREASE_INDEX: increase_idx_q <= cfg_data[3:0];
					REG_DECREASE_INDEX: decrease_idx_q <= cfg_data[3:0];
					default: ;
				endcase
			end
			if (cmd.clear_jog) begin
				active_q <= 1'b0;
				prev_q   <= '0;
			end
			if (cmd.joy_apply) begin
				if (!btn_dead) begin
					active_q <= 1'b0;
					prev_q   <= '0;
					if (meas_valid_q) joint_q <= meas_q;
				end else if (btn_inc) begin
					target_q <= {1'b0, jog_speed_q};
					active_q <= 1'b1;
				end else if (btn_dec) begin
					target_q <= 32'd0 - {1'b0, jog_speed_q};
					active_q <= 1'b1;
				end else begin
					target_q <= '0;
				end
			end
			if (cmd.update_en) begin
				joint_q <= clamp34[31:0];
				prev_q  <= vel_q;
			end
		end
	end

	// item capture and working registers
	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			op_q         <= in_operation;
			buttons_q    <= in_buttons;
			meas_q       <= in_measured_position;
			meas_valid_q <= in_measured_valid;
			dt_q         <= in_elapsed_time;
		end
		if (cmd.mul_en) prod_q <= prod;
		if (cmd.ramp_en) vel_q <= ramp34[31:0];
		if (cmd.goal_en) begin
			gv_q <= vel_q;
			gp_q <= clamp34[31:0];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.joy_apply || cmd.update_en) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.joy_apply) begin
			kind_q    <= KIND_REPLY;
			sup_q     <= btn_dead & suppress_q;
			pos_out_q <= '0;
			vel_out_q <= '0;
		end else if (cmd.update_en) begin
			kind_q    <= KIND_GOAL;
			sup_q     <= 1'b0;
			pos_out_q <= gp_q;
			vel_out_q <= gv_q;
		end
	end

	assign out_valid            = out_valid_q;
	assign out_result_kind      = kind_q;
	assign out_suppress_request = sup_q;
	assign out_goal_position    = pos_out_q;
	assign out_goal_velocity    = vel_out_q;

endmodule
`default_nettype wire

FILE: hw/rtl/joint_jog_ramp_controller.sv
// Joint jog ramp controller: a single-joint jog with slew-rate-limited
// velocity and a position clamp. Channels:
//   s_axis: one item per transfer; tuser is the operation (joystick sample,
//     tick, stop), tdata packs buttons, measured position and valid, tick time.
//   m_axis: one result per transfer; tuser is the kind (reply, goal), tdata
//     packs suppress flag, goal position and goal velocity.
//   cfg: register writes, index and data, always ready; write only when idle.
// Timing: s_axis_tready is high only while the sequencer is idle. A joystick
// sample runs through the dispatch and joystick states; its reply is loaded
// as the block returns to idle, when it is ready again. A tick while jogging
// runs through RL, RV, AL, GP, RD, NV, AD, UPD to its goal (two ramps and two
// travel products share one 33x17 multiplier, loaded in RL, AL, RD and AD),
// then takes the next item. Stop and idle ticks leave dispatch with no result.
// A finished result waits in the output register; the next item is still
// accepted, and only its own result waits while m_axis_tready is low.
// Reset clears the jog state, drops m_axis_tvalid and restores the
// register defaults.
`timescale 1ns / 1ps
`default_nettype none
`include "joint_jog_ramp_controller_assert.svh"
module joint_jog_ramp_controller #(
	parameter int BUTTON_COUNT = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	// input items
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	// buttons, measured_position, measured_valid, elapsed_time, zero fill
	input  wire  [((BUTTON_COUNT + 49 + 7) / 8) * 8 - 1:0] s_axis_tdata,
	// operation
	input  wire  [1:0]  s_axis_tuser,
	// results
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	// suppress_request, goal_position, goal_velocity, zero fill
	output logic [71:0] m_axis_tdata,
	// result_kind
	output logic [0:0]  m_axis_tuser,
	// configuration writes
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [2:0]  cfg_index,
	input  wire  [31:0] cfg_data
);
	import jjr_pkg::*;

	localparam int POS_LO   = BUTTON_COUNT;
	localparam int VALID_AT = BUTTON_COUNT + 32;
	localparam int TIME_LO  = BUTTON_COUNT + 33;

	cmd_t    cmd;
	status_t status;

	logic        kind, sup;
	logic [31:0] goal_pos, goal_vel;

	jjr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	jjr_dp #(
		.BUTTON_COUNT (BUTTON_COUNT)
	) u_dp (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cfg_valid            (cfg_valid),
		.cfg_ready            (cfg_ready),
		.cfg_index            (cfg_index),
		.cfg_data             (cfg_data),
		.in_operation         (s_axis_tuser),
		.in_buttons           (s_axis_tdata[BUTTON_COUNT-1:0]),
		.in_measured_position (s_axis_tdata[POS_LO+31:POS_LO]),
		.in_measured_valid    (s_axis_tdata[VALID_AT]),
		.in_elapsed_time      (s_axis_tdata[TIME_LO+15:TIME_LO]),
		.out_valid            (m_axis_tvalid),
		.out_ready            (m_axis_tready),
		.out_result_kind      (kind),
		.out_suppress_request (sup),
		.out_goal_position    (goal_pos),
		.out_goal_velocity    (goal_vel),
		.cmd                  (cmd),
		.status               (status)
	);

	// pack the result fields, lowest first
	assign m_axis_tdata = {7'b0000000, goal_vel, goal_pos, sup};
	assign m_axis_tuser = kind;

	// the sequencer is busy right after an input transfer
	`JJR_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
	// a new result is only loaded while the sequencer is busy
	`JJR_ASSERT_IMPLY(a_result_from_busy, $rose(m_axis_tvalid), !$past(s_axis_tready))
	// a reply never carries a goal
	`JJR_ASSERT_IMPLY(a_reply_no_goal, m_axis_tvalid && $rose(m_axis_tvalid) && m_axis_tuser[0] == KIND_REPLY, m_axis_tdata[64:1] == 64'd0)

endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
// Self-checking testbench for the joint jog ramp controller: directed table, then random phases.
// Depends on jjr_pkg and joint_jog_ramp_controller; results are checked against an in-line predictor.
`timescale 1ns / 1ps
module tb;
	import jjr_pkg::*;

	// operation code the block must ignore
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int PHASES = 9;
	localparam int PHASE_ITEMS = 103;
	localparam int PRESSURE_PHASE = 5;
	localparam int SETTLE_CYCLES = 24;
	localparam int DRAIN_LIMIT = 5000;

	typedef struct packed {
		logic [1:0]         op;
		logic [15:0]        buttons;
		logic signed [31:0] measured;
		logic               measured_ok;
		logic [15:0]        elapsed;
	} jog_item_t;

	typedef struct packed {
		logic               kind;
		logic               suppress;
		logic signed [31:0] position;
		logic signed [31:0] velocity;
	} jog_result_t;

	// quiet_reply: reply with no suppress request and zero goal, typed in by hand
	typedef struct packed {
		jog_item_t item;
		logic      quiet_reply;
	} jog_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [71:0] s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [71:0] m_axis_tdata;
	logic [0:0]  m_axis_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;

	// predicted joint state
	int          joint_pos;
	int          target_vel;
	int          ramp_vel;
	bit          jog_on;
	// predicted register contents
	int          min_pos;
	int          max_pos;
	logic [30:0] speed;
	logic [30:0] accel;
	bit          suppress;
	logic [3:0]  deadman_bit;
	logic [3:0]  up_bit;
	logic [3:0]  down_bit;

	jog_result_t pending_results[$];
	jog_row_t    directed_rows[$];
	jog_result_t want;
	logic [31:0] cfg_plan [8];
	int          error_count = 0;
	int          send_idle_pct;
	int          recv_stall_pct;

	joint_jog_ramp_controller dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// move the ramp velocity toward the target by at most (accel * span) >> 16
	function automatic longint ramp_toward(input longint span);
		longint step_v;
		longint r;
		step_v = (longint'(accel) * span) >>> 16;
		if (target_vel > ramp_vel) begin
			r = ramp_vel + step_v;
			if (r > target_vel)
				r = target_vel;
		end else begin
			r = ramp_vel - step_v;
			if (r < target_vel)
				r = target_vel;
		end
		return r;
	endfunction

	// trapezoid travel over span, floored, then clamp (min wins when bounds cross)
	function automatic longint travel_to(input longint vel, input longint span);
		longint pos;
		pos = longint'(joint_pos) + (((vel + longint'(ramp_vel)) * span) >>> 17);
		if (pos > longint'(max_pos))
			pos = max_pos;
		if (pos < longint'(min_pos))
			pos = min_pos;
		return pos;
	endfunction

	// advance the predicted state by one item; returns 1 when a result is due
	function automatic bit predict_jog_result(input jog_item_t it, output jog_result_t res);
		longint goal_v;
		longint goal_p;
		longint next_v;
		res = '0;
		case (it.op)
		OP_JOYSTICK: begin
			res.kind = KIND_REPLY;
			if (!it.buttons[deadman_bit]) begin
				jog_on = 1'b0;
				ramp_vel = 0;
				if (it.measured_ok)
					joint_pos = it.measured;
			end else begin
				// increase wins when both jog buttons are held
				if (it.buttons[up_bit]) begin
					target_vel = int'({1'b0, speed});
					jog_on = 1'b1;
				end else if (it.buttons[down_bit]) begin
					target_vel = -int'({1'b0, speed});
					jog_on = 1'b1;
				end else begin
					target_vel = 0;
				end
				res.suppress = suppress;
			end
			return 1'b1;
		end
		OP_TICK: begin
			if (!jog_on)
				return 1'b0;
			goal_v = ramp_toward(LOOKAHEAD_TIME);
			goal_p = travel_to(goal_v, LOOKAHEAD_TIME);
			next_v = ramp_toward(it.elapsed);
			joint_pos = int'(travel_to(next_v, it.elapsed));
			ramp_vel = int'(next_v);
			res.kind = KIND_GOAL;
			res.position = goal_p[31:0];
			res.velocity = goal_v[31:0];
			return 1'b1;
		end
		OP_STOP: begin
			jog_on = 1'b0;
			ramp_vel = 0;
		end
		default: ;
		endcase
		return 1'b0;
	endfunction

	function automatic void write_register(input logic [2:0] index, input logic [31:0] data);
		case (index)
		REG_MIN_POSITION:   min_pos = data;
		REG_MAX_POSITION:   max_pos = data;
		REG_JOG_SPEED:      speed = data[30:0];
		REG_ACCEL_LIMIT:    accel = data[30:0];
		REG_SUPPRESS_LOWER: suppress = data[0];
		REG_DEADMAN_INDEX:  deadman_bit = data[3:0];
		REG_INCREASE_INDEX: up_bit = data[3:0];
		REG_DECREASE_INDEX: down_bit = data[3:0];
		default: ;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint exp_v);
		$display("%0t: %s differs: got %0d, expected %0d", $time, what, got, exp_v);
		error_count++;
	endtask

	task automatic put_row(input logic [1:0] op, input logic [15:0] buttons,
			input logic [31:0] measured, input logic ok, input logic [15:0] elapsed,
			input logic quiet);
		jog_row_t row;
		row.item.op = op;
		row.item.buttons = buttons;
		row.item.measured = measured;
		row.item.measured_ok = ok;
		row.item.elapsed = elapsed;
		row.quiet_reply = quiet;
		directed_rows.insert(directed_rows.size(), row);
	endtask

	// present one item from a falling edge, hold until the transfer, then idle at random
	task automatic send_item(input jog_item_t it, input logic quiet);
		jog_result_t res;
		bit has_result;
		s_axis_tvalid = 1'b1;
		s_axis_tuser = it.op;
		s_axis_tdata = {7'd0, it.elapsed, it.measured_ok, it.measured, it.buttons};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		has_result = predict_jog_result(it, res);
		if (has_result) begin
			if (quiet) begin
				res = '0;
				res.kind = KIND_REPLY;
			end
			pending_results.insert(pending_results.size(), res);
		end
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
	endtask

	// wait out every pending result and any silent work before a register write
	task automatic drain_and_settle();
		while (pending_results.size() != 0 || !s_axis_tready)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic load_settings();
		for (int r = REG_MIN_POSITION; r <= REG_DECREASE_INDEX; r++) begin
			cfg_valid = 1'b1;
			cfg_index = 3'(r);
			cfg_data = cfg_plan[r];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			write_register(cfg_index, cfg_data);
			@(negedge clk);
		end
		cfg_valid = 1'b0;
	endtask

	// register settings per phase: defaults (suppress on), wide extremes, all zero, crossed clamps, random
	task automatic plan_settings(input int ph);
		case (ph)
		0: begin
			cfg_plan[REG_MIN_POSITION] = 32'd0;
			cfg_plan[REG_MAX_POSITION] = 32'd26214;
			cfg_plan[REG_JOG_SPEED] = 32'd4915;
			cfg_plan[REG_ACCEL_LIMIT] = 32'd16384;
			cfg_plan[REG_SUPPRESS_LOWER] = 32'd1;
			cfg_plan[REG_DEADMAN_INDEX] = 32'd10;
			cfg_plan[REG_INCREASE_INDEX] = 32'd12;
			cfg_plan[REG_DECREASE_INDEX] = 32'd14;
		end
		1: begin
			cfg_plan[REG_MIN_POSITION] = 32'h8000_0000;
			cfg_plan[REG_MAX_POSITION] = 32'h7FFF_FFFF;
			cfg_plan[REG_JOG_SPEED] = 32'hFFFF_FFFF;
			cfg_plan[REG_ACCEL_LIMIT] = 32'h7FFF_FFFF;
			cfg_plan[REG_SUPPRESS_LOWER] = 32'hFFFF_FFFF;
			cfg_plan[REG_DEADMAN_INDEX] = 32'hFFFF_FFFF;
			cfg_plan[REG_INCREASE_INDEX] = 32'd0;
			cfg_plan[REG_DECREASE_INDEX] = 32'd15;
		end
		2: begin
			foreach (cfg_plan[r])
				cfg_plan[r] = 32'd0;
		end
		3: begin
			cfg_plan[REG_MIN_POSITION] = 32'd5000;
			cfg_plan[REG_MAX_POSITION] = -32'sd5000;
			cfg_plan[REG_JOG_SPEED] = $urandom_range(0, 1 << 18);
			cfg_plan[REG_ACCEL_LIMIT] = $urandom_range(0, 1 << 20);
			cfg_plan[REG_SUPPRESS_LOWER] = $urandom;
			cfg_plan[REG_DEADMAN_INDEX] = $urandom;
			cfg_plan[REG_INCREASE_INDEX] = $urandom;
			cfg_plan[REG_DECREASE_INDEX] = $urandom;
		end
		8: begin
			foreach (cfg_plan[r])
				cfg_plan[r] = $urandom;
		end
		default: begin
			cfg_plan[REG_MIN_POSITION] = -int'($urandom_range(0, 1 << 22));
			cfg_plan[REG_MAX_POSITION] = cfg_plan[REG_MIN_POSITION] + $urandom_range(0, 1 << 23);
			cfg_plan[REG_JOG_SPEED] = $urandom_range(1, 1 << 18);
			cfg_plan[REG_ACCEL_LIMIT] = $urandom_range(0, 1 << 20);
			cfg_plan[REG_SUPPRESS_LOWER] = $urandom;
			cfg_plan[REG_DEADMAN_INDEX] = $urandom;
			cfg_plan[REG_INCREASE_INDEX] = $urandom;
			cfg_plan[REG_DECREASE_INDEX] = $urandom;
		end
		endcase
	endtask

	// mostly enabled jog samples and ticks, with some stops, releases and unused codes
	function automatic jog_item_t random_item();
		jog_item_t it;
		int unsigned pick;
		pick = $urandom_range(99);
		it.buttons = 16'($urandom);
		if ($urandom_range(1) == 1)
			it.measured = $urandom;
		else
			it.measured = max_pos - int'($urandom_range(0, 1 << 17));
		it.measured_ok = ($urandom_range(4) != 0);
		case ($urandom_range(9))
		0: it.elapsed = 16'h0000;
		1: it.elapsed = 16'hFFFF;
		2, 3, 4, 5: it.elapsed = 16'($urandom);
		default: it.elapsed = 16'($urandom_range(800, 8000));
		endcase
		if (pick < 3) begin
			it.op = OP_UNUSED;
		end else if (pick < 37) begin
			it.op = OP_JOYSTICK;
			if ($urandom_range(99) < 85) begin
				case ($urandom_range(3))
				0: it.buttons[up_bit] = 1'b1;
				1: begin
					it.buttons[up_bit] = 1'b0;
					it.buttons[down_bit] = 1'b1;
				end
				2: begin
					it.buttons[up_bit] = 1'b1;
					it.buttons[down_bit] = 1'b1;
				end
				default: begin
					it.buttons[up_bit] = 1'b0;
					it.buttons[down_bit] = 1'b0;
				end
				endcase
				it.buttons[deadman_bit] = 1'b1;
			end
		end else if (pick < 41) begin
			it.op = OP_STOP;
		end else begin
			it.op = OP_TICK;
		end
		return it;
	endfunction

	// check each result transfer against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result, pending count", 1, 0);
			end else begin
				want = pending_results.pop_front();
				if (m_axis_tuser[0] !== want.kind)
					report_mismatch("result_kind", m_axis_tuser[0], want.kind);
				if (m_axis_tdata[0] !== want.suppress)
					report_mismatch("suppress_request", m_axis_tdata[0], want.suppress);
				if (m_axis_tdata[32:1] !== want.position)
					report_mismatch("goal_position", $signed(m_axis_tdata[32:1]),
						want.position);
				if (m_axis_tdata[64:33] !== want.velocity)
					report_mismatch("goal_velocity", $signed(m_axis_tdata[64:33]),
						want.velocity);
			end
		end
	end

	// result-side back-pressure
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// stimulus
	initial begin
		jog_item_t it;
		int accepted;
		int waited;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = OP_JOYSTICK;
		cfg_valid = 1'b0;
		cfg_index = REG_MIN_POSITION;
		cfg_data = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		joint_pos = 0;
		target_vel = 0;
		ramp_vel = 0;
		jog_on = 1'b0;
		min_pos = 0;
		max_pos = 26214;
		speed = 31'd4915;
		accel = 31'd16384;
		suppress = 1'b0;
		deadman_bit = 4'd10;
		up_bit = 4'd12;
		down_bit = 4'd14;

		// directed rows run on the reset register values: enable bit 10, up 12, down 14
		put_row(OP_JOYSTICK, 16'h0000, 32'h0000_3000, 1'b1, 16'h0000, 1'b1);
		put_row(OP_TICK, 16'h0000, 32'h0, 1'b0, 16'h4000, 1'b0);      // idle tick, silent
		put_row(OP_JOYSTICK, 16'h1400, 32'h0, 1'b0, 16'h0000, 1'b1);
		put_row(OP_TICK, 16'h0000, 32'h0, 1'b0, 16'h0000, 1'b0);      // zero elapsed time
		put_row(OP_TICK, 16'h0000, 32'h0, 1'b0, 16'hFFFF, 1'b0);
		put_row(OP_TICK, 16'h0000, 32'h0, 1'b0, 16'h1999, 1'b0);
		put_row(OP_JOYSTICK, 16'h5400, 32'h0, 1'b0, 16'h0000, 1'b1);  // both jog buttons
		repeat (4)
			put_row(OP_TICK, 16'h0000, 32'h0, 1'b0, 16'hFFFF, 1'b0);  // run into max clamp
		put_row(OP_JOYSTICK, 16'h4400, 32'h0, 1'b0, 16'h0000, 1'b1);
		repeat (4)
			put_row(OP_TICK, 16'h0000, 32'h0, 1'b0, 16'hFFFF, 1'b0);
		put_row(OP_JOYSTICK, 16'h0400, 32'h0, 1'b0, 16'h0000, 1'b1);  // enable only
		put_row(OP_TICK, 16'h0000, 32'h0, 1'b0, 16'h8000, 1'b0);
		put_row(OP_STOP, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 1'b0);
		put_row(OP_TICK, 16'h0000, 32'h0, 1'b0, 16'hFFFF, 1'b0);
		put_row(OP_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 1'b0);
		put_row(OP_JOYSTICK, 16'hFFFF, 32'h7FFF_FFFF, 1'b1, 16'hFFFF, 1'b1);
		put_row(OP_JOYSTICK, 16'h0000, 32'h8000_0000, 1'b1, 16'h0000, 1'b1);
		put_row(OP_JOYSTICK, 16'hFFFF, 32'h0, 1'b0, 16'h0000, 1'b1);
		put_row(OP_TICK, 16'h0000, 32'h0, 1'b0, 16'hFFFF, 1'b0);      // far below min clamp

		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			send_item(directed_rows[i].item, directed_rows[i].quiet_reply);
		s_axis_tvalid = 1'b0;

		for (int ph = 0; ph < PHASES; ph++) begin
			drain_and_settle();
			plan_settings(ph);
			load_settings();
			case (ph % 4)
			0: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			1: begin
				send_idle_pct = 61;
				recv_stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				recv_stall_pct = 61;
			end
			default: begin
				send_idle_pct = 36;
				recv_stall_pct = 36;
			end
			endcase
			accepted = 0;
			while (accepted < PHASE_ITEMS) begin
				it = random_item();
				send_item(it, 1'b0);
				accepted++;
				// hold the sender until every pending result is out
				if (ph == PRESSURE_PHASE && accepted % 30 == 29) begin
					s_axis_tvalid = 1'b0;
					while (pending_results.size() != 0)
						@(posedge clk);
					@(negedge clk);
				end
			end
			s_axis_tvalid = 1'b0;
		end

		waited = 0;
		while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (pending_results.size() != 0)
			report_mismatch("results never delivered", 0, pending_results.size());
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("joint_jog_ramp_controller: match");
		else
			$display("joint_jog_ramp_controller: mismatch");
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("joint_jog_ramp_controller: mismatch");
		$finish;
	end

endmodule
